### design/kbq_pkg.sv
package kbq_pkg;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic [2:0] OP_SCAN   = 3'd0;
  localparam logic [2:0] OP_POLL   = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_RATE  = 1'b1;

  localparam logic [6:0] KEY_CAPS_LOCK   = 7'h3A;
  localparam logic [6:0] KEY_NUM_LOCK    = 7'h45;
  localparam logic [6:0] KEY_SCROLL_LOCK = 7'h46;

  localparam logic [15:0] DELAY_RESET = 16'd30;
  localparam logic [15:0] RATE_RESET  = 16'd5;

  typedef struct packed {
    logic toggled;
    logic down;
  } key_st_t;

  typedef struct packed {
    logic       rd_en;
    logic [6:0] rd_addr;
    logic       wr_en;
    logic [6:0] wr_addr;
    key_st_t    wr_data;
  } kt_req_t;

endpackage

### design/kbq_key_table.sv
module kbq_key_table #(
  parameter int KEY_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kbq_pkg::kt_req_t  req,
  output kbq_pkg::key_st_t  rd_st
);
  import kbq_pkg::*;

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  key_st_t              mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_r;
  key_st_t              rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[KW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[KW-1:0]];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr[KW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr[KW-1:0]];
      end
    end
  end

  assign rd_st = rd_vld_r ? rd_data_r : '0;

endmodule

### design/keyboard_event_queue_with_repeat.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_operation, in_code, in_released
// out       output     out_valid / out_ready  out_event_*, out_key_down, out_key_toggled
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// each item is accepted in idle, which issues the event store and key table reads;
// the execute state uses the registered read data, writes back and loads the result.
// an item is accepted while a result waits; its write-back waits until out is free.
// reset is synchronous; the key table is cleared at once by per-entry valid bits.
// the event store is not cleared, a poll only reads slots written before.
module keyboard_event_queue_with_repeat #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_COUNT   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_code,
  input  logic        in_released,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_event_valid,
  output logic [6:0]  out_event_code,
  output logic        out_event_released,
  output logic        out_key_down,
  output logic        out_key_toggled,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import kbq_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  state_t state_r, state_nxt;
  logic   accept, commit;

  logic [2:0] op_r;
  logic [7:0] code_r;
  logic       rel_r;

  logic [7:0]    event_store [QUEUE_DEPTH];
  logic [7:0]    ev_rd_r;
  logic [QW-1:0] rp_r, wp_r, rp_inc, wp_inc;
  logic          q_empty, q_full;

  logic [6:0]  repeat_key_r, repeat_key_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [15:0] delay_r, rate_r;

  logic        out_valid_r;
  logic        out_event_valid_r, out_event_released_r, out_key_down_r, out_key_toggled_r;
  logic [6:0]  out_event_code_r;

  kt_req_t kt_req;
  key_st_t kt_st, st_new;

  logic       push_req, push_en, poll_take, in_rng, is_lock;
  logic [7:0] push_data;
  logic       o_ev_valid, o_ev_rel, o_down, o_tog;
  logic [6:0] o_ev_code;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_valid && in_ready;
    commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  assign rp_inc  = (rp_r == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wp_inc  = (wp_r == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign q_empty = (rp_r == wp_r);
  assign q_full  = (wp_inc == rp_r);

  assign in_rng  = (code_r < 8'(KEY_COUNT));
  assign is_lock = code_r[6:0] inside {KEY_CAPS_LOCK, KEY_NUM_LOCK, KEY_SCROLL_LOCK};

  // item execution on the registered read data
  always_comb begin
    push_req       = 1'b0;
    push_data      = code_r;
    poll_take      = 1'b0;
    st_new         = kt_st;
    repeat_key_nxt = repeat_key_r;
    armed_nxt      = armed_r;
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    o_ev_valid     = 1'b0;
    o_ev_code      = '0;
    o_ev_rel       = 1'b0;
    o_down         = 1'b0;
    o_tog          = 1'b0;
    case (op_r)
      OP_SCAN: begin
        push_req = 1'b1;
      end
      OP_POLL: begin
        if (!q_empty) begin
          poll_take  = 1'b1;
          o_ev_valid = 1'b1;
          o_ev_code  = ev_rd_r[6:0];
          o_ev_rel   = ev_rd_r[7];
        end
      end
      OP_UPDATE: begin
        if (in_rng) begin
          if (!rel_r) begin
            if (is_lock && !kt_st.down) st_new.toggled = ~kt_st.toggled;
            st_new.down    = 1'b1;
            repeat_key_nxt = code_r[6:0];
            count_nxt      = '0;
            phase_nxt      = '0;
            armed_nxt      = 1'b1;
          end else begin
            st_new.down = 1'b0;
            if (repeat_key_r == code_r[6:0]) armed_nxt = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (armed_r) begin
          if (count_r < delay_r) begin
            count_nxt = count_r + 16'd1;
            if (count_nxt == delay_r) begin
              phase_nxt = '0;
              push_req  = 1'b1;
              push_data = {1'b0, repeat_key_r};
            end
          end else begin
            phase_nxt = phase_r + 16'd1;
            if (phase_nxt >= rate_r) begin
              phase_nxt = '0;
              push_req  = 1'b1;
              push_data = {1'b0, repeat_key_r};
            end
          end
        end
      end
      OP_QUERY: begin
        if (in_rng) begin
          o_down = kt_st.down;
          o_tog  = kt_st.toggled;
        end
      end
      default: ;
    endcase
  end

  assign push_en = push_req && !q_full;

  always_comb begin
    kt_req.rd_en   = accept;
    kt_req.rd_addr = in_code[6:0];
    kt_req.wr_en   = commit && (op_r == OP_UPDATE) && in_rng;
    kt_req.wr_addr = code_r[6:0];
    kt_req.wr_data = st_new;
  end

  kbq_key_table #(
    .KEY_COUNT (KEY_COUNT)
  ) u_key_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (kt_req),
    .rd_st (kt_st)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_rd_r <= event_store[rp_r];
    end
    if (commit && push_en) begin
      event_store[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      code_r <= in_code;
      rel_r  <= in_released;
    end
    if (commit) begin
      out_event_valid_r    <= o_ev_valid;
      out_event_code_r     <= o_ev_code;
      out_event_released_r <= o_ev_rel;
      out_key_down_r       <= o_down;
      out_key_toggled_r    <= o_tog;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rp_r         <= '0;
      wp_r         <= '0;
      repeat_key_r <= '0;
      armed_r      <= 1'b0;
      count_r      <= '0;
      phase_r      <= '0;
      delay_r      <= DELAY_RESET;
      rate_r       <= RATE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        if (push_en)   wp_r <= wp_inc;
        if (poll_take) rp_r <= rp_inc;
        repeat_key_r <= repeat_key_nxt;
        armed_r      <= armed_nxt;
        count_r      <= count_nxt;
        phase_r      <= phase_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY: delay_r <= cfg_data;
          CFG_RATE:  rate_r  <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_valid    = out_event_valid_r;
  assign out_event_code     = out_event_code_r;
  assign out_event_released = out_event_released_r;
  assign out_key_down       = out_key_down_r;
  assign out_key_toggled    = out_key_toggled_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted item did not move to execute");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_valid_r && !out_ready |=> (state_r == S_EXEC) && out_valid_r)
    else $error("write-back did not wait for a stalled result");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("finished item produced no result");

  a_poll_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_valid_r |-> !out_key_down_r && !out_key_toggled_r)
    else $error("poll result carries query bits");

endmodule

### verif/keyboard_event_queue_with_repeat_test.sv
module keyboard_event_queue_with_repeat_test;
  import kbq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int KEYS = 128;

  typedef struct packed {
    logic       ev_valid;
    logic [6:0] ev_code;
    logic       ev_rel;
    logic       down;
    logic       toggled;
  } kbd_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = OP_POLL;
  logic [7:0]  in_code = '0;
  logic        in_released = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_event_valid;
  logic [6:0]  out_event_code;
  logic        out_event_released;
  logic        out_key_down;
  logic        out_key_toggled;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DELAY;
  logic [15:0] cfg_data = '0;

  // predicted block state
  logic [7:0]  event_slot [SLOTS];
  logic [3:0]  rd_ptr = '0;
  logic [3:0]  wr_ptr = '0;
  key_st_t     key_bits [KEYS];
  logic [6:0]  rpt_key = '0;
  logic        rpt_armed = 1'b0;
  logic [15:0] rpt_count = '0;
  logic [15:0] rpt_phase = '0;
  logic [15:0] delay_reg = DELAY_RESET;
  logic [15:0] rate_reg = RATE_RESET;

  kbd_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int repeats_queued = 0;
  int events_dropped = 0;
  int chunk_no = 0;

  keyboard_event_queue_with_repeat i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_code            (in_code),
    .in_released        (in_released),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_valid    (out_event_valid),
    .out_event_code     (out_event_code),
    .out_event_released (out_event_released),
    .out_key_down       (out_key_down),
    .out_key_toggled    (out_key_toggled),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ring holds SLOTS-1 events, a push into a full ring is dropped
  function automatic void enqueue_event(logic [6:0] key, logic rel);
    if (4'(wr_ptr + 4'd1) == rd_ptr) begin
      events_dropped++;
    end else begin
      event_slot[wr_ptr] = {rel, key};
      wr_ptr = wr_ptr + 4'd1;
    end
  endfunction

  function automatic kbd_result_t next_keyboard_result(logic [2:0] op, logic [7:0] code,
                                                       logic rel);
    kbd_result_t res;
    key_st_t     st;
    logic [6:0]  k;
    res = '0;
    k = code[6:0];
    case (op)
      OP_SCAN: enqueue_event(code[6:0], code[7]);
      OP_POLL: begin
        if (rd_ptr != wr_ptr) begin
          res.ev_valid = 1'b1;
          res.ev_code = event_slot[rd_ptr][6:0];
          res.ev_rel = event_slot[rd_ptr][7];
          rd_ptr = rd_ptr + 4'd1;
        end
      end
      OP_UPDATE: begin
        if (code < KEYS) begin
          st = key_bits[k];
          if (!rel) begin
            if ((k == KEY_CAPS_LOCK || k == KEY_NUM_LOCK || k == KEY_SCROLL_LOCK) && !st.down)
              st.toggled = ~st.toggled;
            st.down = 1'b1;
            rpt_key = k;
            rpt_count = '0;
            rpt_phase = '0;
            rpt_armed = 1'b1;
          end else begin
            st.down = 1'b0;
            if (rpt_key == k)
              rpt_armed = 1'b0;
          end
          key_bits[k] = st;
        end
      end
      OP_TICK: begin
        if (rpt_armed) begin
          if (rpt_count < delay_reg) begin
            rpt_count = rpt_count + 16'd1;
            if (rpt_count == delay_reg) begin
              rpt_phase = '0;
              repeats_queued++;
              enqueue_event(rpt_key, 1'b0);
            end
          end else begin
            rpt_phase = rpt_phase + 16'd1;
            // a rate of zero behaves like one
            if (rpt_phase >= rate_reg) begin
              rpt_phase = '0;
              repeats_queued++;
              enqueue_event(rpt_key, 1'b0);
            end
          end
        end
      end
      OP_QUERY: begin
        if (code < KEYS) begin
          res.down = key_bits[k].down;
          res.toggled = key_bits[k].toggled;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(logic [2:0] op, logic [7:0] code, logic rel);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_code <= code;
    in_released <= rel;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
    pending_results.push_back(next_keyboard_result(op, code, rel));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    // let the last item's write-back settle
    repeat (4) @(posedge clk);
  endtask

  task automatic set_repeat(logic [15:0] dly, logic [15:0] rate);
    wait_for_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELAY;
    cfg_data <= dly;
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_reg = dly;
    rate_reg = rate;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    kbd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("event_valid", 7'(want.ev_valid), 7'(out_event_valid));
        check_field("event_code", want.ev_code, out_event_code);
        check_field("event_released", 7'(want.ev_rel), 7'(out_event_released));
        check_field("key_down", 7'(want.down), 7'(out_key_down));
        check_field("key_toggled", 7'(want.toggled), 7'(out_key_toggled));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_basic_ops();
    send_item(OP_POLL, 8'h00, 1'b0);      // empty queue
    send_item(OP_SCAN, 8'h00, 1'b1);
    send_item(OP_SCAN, 8'hFF, 1'b0);
    send_item(OP_POLL, 8'hFF, 1'b1);
    send_item(OP_POLL, 8'h00, 1'b0);
    send_item(OP_UPDATE, 8'hFF, 1'b0);    // out of range, ignored
    send_item(OP_QUERY, 8'h80, 1'b1);
    send_item(OP_UPDATE, {1'b0, KEY_CAPS_LOCK}, 1'b0);
    send_item(OP_UPDATE, {1'b0, KEY_CAPS_LOCK}, 1'b0);  // already down, no flip
    send_item(OP_QUERY, {1'b0, KEY_CAPS_LOCK}, 1'b0);
    send_item(OP_UPDATE, {1'b0, KEY_CAPS_LOCK}, 1'b1);
    send_item(OP_QUERY, {1'b0, KEY_CAPS_LOCK}, 1'b0);
    send_item(OP_TICK, 8'h00, 1'b0);      // repeat disarmed
    for (int op = OP_QUERY + 1; op < 8; op++)
      send_item(3'(op), 8'hA5, 1'b1);
  endtask

  task automatic test_repeat_timing();
    set_repeat(16'd0, 16'd0);
    send_item(OP_UPDATE, 8'h20, 1'b0);
    repeat (3) send_item(OP_TICK, 8'h00, 1'b0);
    // new settings take effect on a running repeat
    set_repeat(16'd2, 16'd1);
    repeat (3) send_item(OP_TICK, 8'h00, 1'b0);
    send_item(OP_UPDATE, 8'h20, 1'b1);
  endtask

  task automatic test_random_traffic(int chunks, int chunk_items);
    int          pick;
    int          poll_share;
    logic [2:0]  op;
    logic [7:0]  code;
    logic        rel;
    for (int c = 0; c < chunks; c++) begin
      case (chunk_no)
        1: set_repeat(16'hFFFF, 16'hFFFF);
        4: set_repeat(16'd0, 16'd1);
        7: set_repeat(16'hFFFF, 16'd1);
        10: set_repeat(16'd1, 16'hFFFF);
        default: set_repeat(16'($urandom_range(4)), 16'($urandom_range(1, 3)));
      endcase
      // few polls in odd chunks so the ring fills up and drops
      poll_share = (chunk_no % 2) ? 6 : 25;
      chunk_no++;
      repeat (chunk_items) begin
        pick = $urandom_range(99);
        code = 8'($urandom);
        rel = 1'($urandom);
        if (pick < 18)
          op = OP_SCAN;
        else if (pick < 18 + poll_share)
          op = OP_POLL;
        else if (pick < 28 + poll_share)
          op = OP_UPDATE;
        else if (pick < 34 + poll_share)
          op = OP_QUERY;
        else if (pick < 98)
          op = OP_TICK;
        else
          op = 3'($urandom_range(OP_QUERY + 1, 7));
        if (op == OP_UPDATE || op == OP_QUERY) begin
          case ($urandom_range(3))
            0: code = 8'($urandom);
            1: begin
              case ($urandom_range(2))
                0: code = {1'b0, KEY_CAPS_LOCK};
                1: code = {1'b0, KEY_NUM_LOCK};
                default: code = {1'b0, KEY_SCROLL_LOCK};
              endcase
            end
            default: code = 8'($urandom_range(5));
          endcase
        end
        send_item(op, code, rel);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < KEYS; i++)
      key_bits[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 46;
    test_basic_ops();
    test_repeat_timing();
    test_random_traffic(4, 50);

    send_idle_pct = 46;
    recv_idle_pct = 14;
    test_random_traffic(4, 50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(4, 50);

    wait_for_idle();
    repeat (10) @(posedge clk);

    $display("%0d items sent, %0d results checked", items_sent, results_checked);
    $display("%0d repeat presses generated, %0d events dropped on a full queue",
             repeats_queued, events_dropped);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
